[rtl/core/lobm_pkg.sv]
// Package for the limit order batch matcher.
// Holds sizes, result codes and the order record carried by the cell ring.
// No dependencies.
package lobm_pkg;

    localparam int MAX_ORDERS  = 16;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 16;

    localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int ID_W   = (MAX_ORDERS > 1) ? $clog2(MAX_ORDERS) : 1;
    localparam int CNT_W  = $clog2(MAX_ORDERS + 1);
    localparam int NK_W   = $clog2(MAX_RESULTS);
    localparam int NK_MAX = MAX_RESULTS - 1;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 16;
    localparam int VOL_W   = 20;
    localparam int NOT_W   = 52;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    localparam logic SIDE_SELL = 1'b0;
    localparam logic SIDE_BUY  = 1'b1;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_TRADE   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic               valid;
        logic               side;
        logic [ID_W-1:0]    id;
        logic [TAG_W-1:0]   tag;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   rem;
    } t_order;

    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             wb_en;
        logic [ID_W-1:0]  wb_id;
        logic [QTY_W-1:0] wb_rem;
    } t_cell_ctl;

endpackage

[rtl/core/lobm_req_if.sv]
// Request channel of the limit order batch matcher.
// Valid/ready handshake with the order payload. No dependencies.
interface lobm_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        side;
    logic [15:0] order_id;
    logic [31:0] price;
    logic [15:0] quantity;

    modport source (output valid, req_type, side, order_id, price, quantity, input ready);
    modport sink   (input valid, req_type, side, order_id, price, quantity, output ready);
endinterface

[rtl/core/lobm_res_if.sv]
// Result channel of the limit order batch matcher.
// Valid/ready handshake with status, trade and summary fields. No dependencies.
interface lobm_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [15:0] buy_order_id;
    logic [31:0] trade_price;
    logic [15:0] trade_quantity;
    logic [19:0] total_volume;
    logic [51:0] total_notional;
    logic        last;

    modport source (output valid, result_kind, status, buy_order_id, trade_price,
                    trade_quantity, total_volume, total_notional, last, input ready);
    modport sink   (input valid, result_kind, status, buy_order_id, trade_price,
                    trade_quantity, total_volume, total_notional, last, output ready);
endinterface

[rtl/core/lobm_cell.sv]
// One slot of the order ring: holds a single order record.
// Shifts from its neighbor, clears, or takes a remainder write-back. Uses lobm_pkg.
module lobm_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lobm_pkg::t_cell_ctl i_ctl,
    input  lobm_pkg::t_order   i_d,
    output lobm_pkg::t_order   o_q
);
    import lobm_pkg::*;

    t_order r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_q.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_q <= i_d;
        end else if (i_ctl.wb_en && r_q.valid && r_q.id == i_ctl.wb_id) begin
            r_q.rem <= i_ctl.wb_rem;
        end
    end

    assign o_q = r_q;
endmodule

[rtl/core/limit_order_batch_matcher.sv]
// Limit order batch matcher: a load's status item comes out on the next cycle.
// A match rotates the order ring past one head cell; each search step is a full pass:
// find a buy level, find a crossing sell level, pick a buy at it, fill that buy from
// the sells at the level, write back, then give the summary. Result-side stalls hold it.
// Synchronous active-low reset empties the book and clears both sums.
module limit_order_batch_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lobm_req_if.sink    i_req,
    lobm_res_if.source  o_res
);
    import lobm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND_BP, S_FIND_SP, S_FIND_BUY, S_SELL, S_WB, S_SUM
    } t_state;

    t_state r_state;

    t_order    w_cell [MAX_ORDERS];
    t_order    w_new;
    t_order    w_fb;
    t_cell_ctl w_ctl;

    logic [ID_W-1:0]    r_cnt;
    logic [CNT_W-1:0]   r_count;
    logic [PRICE_W-1:0] r_bp;
    logic               r_have_bp;
    logic [PRICE_W-1:0] r_sp;
    logic               r_have_sp;
    logic [PRICE_W-1:0] r_best;
    logic               r_found;
    logic [ID_W-1:0]    r_cur_id;
    logic               r_first_buy;
    logic [TAG_W-1:0]   r_cur_tag;
    logic [QTY_W-1:0]   r_cur_rem;
    logic [NK_W-1:0]    r_nk;
    logic [VOL_W-1:0]   r_vol;
    logic [NOT_W-1:0]   r_not;
    logic               r_mq_v;
    logic [QTY_W-1:0]   r_mq;
    logic [PRICE_W-1:0] r_mp;
    logic               r_prod_v;
    logic [PRICE_W+QTY_W-1:0] r_prod;

    logic               r_out_valid;
    logic [1:0]         r_o_kind;
    logic [1:0]         r_o_status;
    logic [15:0]        r_o_tag;
    logic [PRICE_W-1:0] r_o_price;
    logic [QTY_W-1:0]   r_o_qty;
    logic [VOL_W-1:0]   r_o_vol;
    logic [NOT_W-1:0]   r_o_not;
    logic               r_o_last;

    t_order             w_head;
    logic               w_can_emit;
    logic               w_ready;
    logic               w_accept;
    logic               w_bad;
    logic               w_push;
    logic               w_rot_active;
    logic               w_sell_hit;
    logic               w_need_emit;
    logic               w_rotate;
    logic               w_pass_end;
    logic [QTY_W-1:0]   w_q;
    logic               w_bp_hit;
    logic               w_sp_hit;
    logic               w_buy_hit;

    assign w_head       = w_cell[0];
    assign w_can_emit   = !r_out_valid || o_res.ready;
    assign w_ready      = (r_state == S_IDLE) && w_can_emit;
    assign w_accept     = i_req.valid && w_ready;
    assign w_bad        = (i_req.price == '0) || (i_req.quantity == '0);
    assign w_push       = w_accept && (i_req.req_type == REQ_LOAD) && !w_bad
                          && (r_count < CNT_W'(MAX_ORDERS));
    assign w_rot_active = (r_state == S_FIND_BP) || (r_state == S_FIND_SP)
                          || (r_state == S_FIND_BUY) || (r_state == S_SELL);
    assign w_sell_hit   = (r_state == S_SELL) && w_head.valid && (w_head.side == SIDE_SELL)
                          && (w_head.price == r_sp) && (w_head.rem != '0)
                          && (r_cur_rem != '0);
    assign w_q          = (r_cur_rem < w_head.rem) ? r_cur_rem : w_head.rem;
    assign w_need_emit  = w_sell_hit && (r_nk < NK_W'(NK_MAX));
    assign w_rotate     = w_rot_active && !(w_need_emit && !w_can_emit);
    assign w_pass_end   = w_rotate && (r_cnt == ID_W'(MAX_ORDERS - 1));

    assign w_bp_hit  = w_head.valid && (w_head.side == SIDE_BUY)
                       && (!r_have_bp || w_head.price < r_bp)
                       && (!r_found || w_head.price > r_best);
    assign w_sp_hit  = w_head.valid && (w_head.side == SIDE_SELL) && (w_head.price <= r_bp)
                       && (!r_have_sp || w_head.price > r_sp)
                       && (!r_found || w_head.price < r_best);
    assign w_buy_hit = !r_found && w_head.valid && (w_head.side == SIDE_BUY)
                       && (w_head.price == r_bp) && (w_head.rem != '0)
                       && (r_first_buy || w_head.id < r_cur_id);

    always_comb begin
        w_new.valid = 1'b1;
        w_new.side  = i_req.side;
        w_new.id    = r_count[ID_W-1:0];
        w_new.tag   = i_req.order_id[TAG_W-1:0];
        w_new.price = i_req.price;
        w_new.rem   = i_req.quantity;
        w_fb        = w_head;
        if (w_sell_hit) begin
            w_fb.rem = w_head.rem - w_q;
        end
        w_ctl.shift  = w_push || w_rotate;
        w_ctl.clear  = (r_state == S_SUM) && w_can_emit;
        w_ctl.wb_en  = (r_state == S_WB);
        w_ctl.wb_id  = r_cur_id;
        w_ctl.wb_rem = r_cur_rem;
    end

    for (genvar k = 0; k < MAX_ORDERS; k++) begin : g_cell
        t_order w_d;
        if (k == 0) begin : g_first
            assign w_d = w_push ? w_new : w_cell[1];
        end else if (k == MAX_ORDERS - 1) begin : g_last
            assign w_d = w_push ? w_cell[k-1] : w_fb;
        end else begin : g_mid
            assign w_d = w_push ? w_cell[k-1] : w_cell[k+1];
        end
        lobm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_d     (w_d),
            .o_q     (w_cell[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_count     <= '0;
            r_have_bp   <= 1'b0;
            r_have_sp   <= 1'b0;
            r_found     <= 1'b0;
            r_first_buy <= 1'b1;
            r_nk        <= '0;
            r_vol       <= '0;
            r_not       <= '0;
            r_mq_v      <= 1'b0;
            r_prod_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_can_emit) begin
                r_out_valid <= 1'b0;
            end
            if (w_rotate) begin
                r_cnt <= w_pass_end ? '0 : r_cnt + 1'b1;
            end

            r_mq_v   <= w_sell_hit && w_rotate;
            r_prod_v <= r_mq_v;
            r_prod   <= r_mp * r_mq;
            if (r_prod_v) begin
                r_not <= r_not + NOT_W'(r_prod);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_req.req_type == REQ_MATCH) begin
                            r_state   <= S_FIND_BP;
                            r_cnt     <= '0;
                            r_have_bp <= 1'b0;
                            r_found   <= 1'b0;
                            r_nk      <= '0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_STATUS;
                            r_o_status  <= w_bad ? ST_INVALID
                                           : (w_push ? ST_OK : ST_FULL);
                            r_o_tag     <= '0;
                            r_o_price   <= '0;
                            r_o_qty     <= '0;
                            r_o_vol     <= '0;
                            r_o_not     <= '0;
                            r_o_last    <= 1'b1;
                            if (w_push) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                S_FIND_BP: begin
                    if (w_bp_hit) begin
                        r_best  <= w_head.price;
                        r_found <= 1'b1;
                    end
                    if (w_pass_end) begin
                        r_found <= 1'b0;
                        if (r_found || w_bp_hit) begin
                            r_bp      <= w_bp_hit ? w_head.price : r_best;
                            r_have_bp <= 1'b1;
                            r_have_sp <= 1'b0;
                            r_state   <= S_FIND_SP;
                        end else begin
                            r_state <= S_SUM;
                        end
                    end
                end
                S_FIND_SP: begin
                    if (w_sp_hit) begin
                        r_best  <= w_head.price;
                        r_found <= 1'b1;
                    end
                    if (w_pass_end) begin
                        r_found <= 1'b0;
                        if (r_found || w_sp_hit) begin
                            r_sp        <= w_sp_hit ? w_head.price : r_best;
                            r_have_sp   <= 1'b1;
                            r_first_buy <= 1'b1;
                            r_state     <= S_FIND_BUY;
                        end else begin
                            r_state <= S_FIND_BP;
                        end
                    end
                end
                S_FIND_BUY: begin
                    if (w_buy_hit) begin
                        r_cur_id  <= w_head.id;
                        r_cur_tag <= w_head.tag;
                        r_cur_rem <= w_head.rem;
                        r_found   <= 1'b1;
                    end
                    if (w_pass_end) begin
                        r_found <= 1'b0;
                        if (r_found || w_buy_hit) begin
                            r_first_buy <= 1'b0;
                            r_state     <= S_SELL;
                        end else begin
                            r_state <= S_FIND_SP;
                        end
                    end
                end
                S_SELL: begin
                    if (w_sell_hit && w_rotate) begin
                        r_cur_rem <= r_cur_rem - w_q;
                        r_vol     <= r_vol + VOL_W'(w_q);
                        r_mq      <= w_q;
                        r_mp      <= r_sp;
                        if (w_need_emit) begin
                            r_nk        <= r_nk + 1'b1;
                            r_out_valid <= 1'b1;
                            r_o_kind    <= KIND_TRADE;
                            r_o_status  <= ST_OK;
                            r_o_tag     <= 16'(r_cur_tag);
                            r_o_price   <= r_sp;
                            r_o_qty     <= w_q;
                            r_o_vol     <= '0;
                            r_o_not     <= '0;
                            r_o_last    <= 1'b0;
                        end
                    end
                    if (w_pass_end) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_found <= 1'b0;
                    r_state <= S_FIND_BUY;
                end
                S_SUM: begin
                    if (w_can_emit) begin
                        r_out_valid <= 1'b1;
                        r_o_kind    <= KIND_SUMMARY;
                        r_o_status  <= ST_OK;
                        r_o_tag     <= '0;
                        r_o_price   <= '0;
                        r_o_qty     <= '0;
                        r_o_vol     <= r_vol;
                        r_o_not     <= r_not;
                        r_o_last    <= 1'b1;
                        r_count     <= '0;
                        r_vol       <= '0;
                        r_not       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready          = w_ready;
    assign o_res.valid          = r_out_valid;
    assign o_res.result_kind    = r_o_kind;
    assign o_res.status         = r_o_status;
    assign o_res.buy_order_id   = r_o_tag;
    assign o_res.trade_price    = r_o_price;
    assign o_res.trade_quantity = r_o_qty;
    assign o_res.total_volume   = r_o_vol;
    assign o_res.total_notional = r_o_not;
    assign o_res.last           = r_o_last;
endmodule

[rtl/core/lobm_chk.sv]
// Port-level checks for the limit order batch matcher, bound to the top level.
// Uses lobm_pkg result codes.
module lobm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_req_type,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic [1:0]  i_status,
    input logic [15:0] i_qty,
    input logic        i_last
);
    import lobm_pkg::*;

    a_load_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_req_type == REQ_LOAD
        |=> i_out_valid && i_kind == KIND_STATUS && i_last)
        else $error("load item gave no status item");

    a_trade_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_TRADE
        |-> !i_last && i_status == ST_OK && i_qty != '0 && !i_in_ready)
        else $error("malformed trade item or request taken during match");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_SUMMARY |-> i_last)
        else $error("summary item not marked last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready
        |=> i_out_valid && $stable(i_kind) && $stable(i_qty) && $stable(i_last))
        else $error("stalled result item changed");
endmodule

bind limit_order_batch_matcher lobm_chk u_lobm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_req_type  (i_req.req_type),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_kind      (o_res.result_kind),
    .i_status    (o_res.status),
    .i_qty       (o_res.trade_quantity),
    .i_last      (o_res.last)
);

[tb/sv/lobm_book_checker.sv]
// Checker for the limit order batch matcher: keeps its own copy of the order book,
// works out the status, trade and summary items of every accepted request and
// compares them with the result channel. Depends on lobm_pkg and both channel interfaces.
module lobm_book_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lobm_req_if   i_req,
    lobm_res_if   i_res,
    output int    o_errors,
    output int    o_pending
);
    import lobm_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] buy_id;
        logic [31:0] price;
        logic [15:0] qty;
        logic [19:0] vol;
        logic [51:0] notional;
        logic        last;
    } t_book_item;

    logic              book_side [MAX_ORDERS];
    logic [15:0]       book_tag  [MAX_ORDERS];
    logic [31:0]       book_price[MAX_ORDERS];
    logic [15:0]       book_rem  [MAX_ORDERS];
    int                book_count;
    logic [VOL_W-1:0]  vol_sum;
    logic [NOT_W-1:0]  notional_sum;
    t_book_item        expected_items[$];
    int                errors;

    assign o_errors  = errors;
    assign o_pending = expected_items.size();

    function automatic t_book_item make_item(logic [1:0] kind, logic [1:0] status,
                                             logic [15:0] id, logic [31:0] price,
                                             logic [15:0] qty, logic [19:0] vol,
                                             logic [51:0] notional, logic last);
        t_book_item it;
        it = '{kind, status, id, price, qty, vol, notional, last};
        return it;
    endfunction

    function automatic bit walks_first(int a, int b, bit buy);
        if (book_price[a] != book_price[b])
            return buy ? book_price[a] > book_price[b] : book_price[a] < book_price[b];
        return a > b;
    endfunction

    function automatic void match_book();
        int bl[MAX_ORDERS];
        int sl[MAX_ORDERS];
        int nb, ns, p, bi, be, sj, se, b, s, k;
        logic [31:0] bp, sp;
        logic [15:0] q;
        nb = 0;
        ns = 0;
        k = 0;
        for (int i = 0; i < book_count; i++) begin
            if (book_side[i] == SIDE_BUY) begin
                p = nb;
                nb++;
                while (p > 0 && walks_first(i, bl[p-1], 1'b1)) begin
                    bl[p] = bl[p-1];
                    p--;
                end
                bl[p] = i;
            end else begin
                p = ns;
                ns++;
                while (p > 0 && walks_first(i, sl[p-1], 1'b0)) begin
                    sl[p] = sl[p-1];
                    p--;
                end
                sl[p] = i;
            end
        end
        bi = 0;
        while (bi < nb) begin
            bp = book_price[bl[bi]];
            be = bi;
            while (be < nb && book_price[bl[be]] == bp) be++;
            sj = 0;
            while (sj < ns && book_price[sl[sj]] <= bp) begin
                sp = book_price[sl[sj]];
                se = sj;
                while (se < ns && book_price[sl[se]] == sp) se++;
                for (int x = bi; x < be; x++) begin
                    for (int y = sj; y < se; y++) begin
                        b = bl[x];
                        s = sl[y];
                        if (book_rem[b] != 0 && book_rem[s] != 0) begin
                            q = (book_rem[b] < book_rem[s]) ? book_rem[b] : book_rem[s];
                            book_rem[b] -= q;
                            book_rem[s] -= q;
                            vol_sum += q;
                            notional_sum += NOT_W'(sp) * NOT_W'(q);
                            if (k < NK_MAX) begin
                                expected_items.push_back(make_item(KIND_TRADE, ST_OK,
                                    book_tag[b], sp, q, '0, '0, 1'b0));
                                k++;
                            end
                        end
                    end
                end
                sj = se;
            end
            bi = be;
        end
        expected_items.push_back(make_item(KIND_SUMMARY, ST_OK, '0, '0, '0,
                                           vol_sum, notional_sum, 1'b1));
        book_count = 0;
        vol_sum = '0;
        notional_sum = '0;
    endfunction

    function automatic void predict_request(logic req_type, logic side, logic [15:0] id,
                                            logic [31:0] price, logic [15:0] qty);
        if (req_type == REQ_MATCH) begin
            match_book();
        end else if (price == 0 || qty == 0) begin
            expected_items.push_back(make_item(KIND_STATUS, ST_INVALID, '0, '0, '0,
                                               '0, '0, 1'b1));
        end else if (book_count >= MAX_ORDERS) begin
            expected_items.push_back(make_item(KIND_STATUS, ST_FULL, '0, '0, '0,
                                               '0, '0, 1'b1));
        end else begin
            book_side[book_count]  = side;
            book_tag[book_count]   = id;
            book_price[book_count] = price;
            book_rem[book_count]   = qty;
            book_count++;
            expected_items.push_back(make_item(KIND_STATUS, ST_OK, '0, '0, '0,
                                               '0, '0, 1'b1));
        end
    endfunction

    always @(posedge i_clk) begin
        t_book_item got;
        t_book_item want;
        if (!i_rst_n) begin
            book_count = 0;
            vol_sum = '0;
            notional_sum = '0;
            expected_items.delete();
            errors = 0;
        end else begin
            if (i_req.valid && i_req.ready)
                predict_request(i_req.req_type, i_req.side, i_req.order_id,
                                i_req.price, i_req.quantity);
            if (i_res.valid && i_res.ready) begin
                got = make_item(i_res.result_kind, i_res.status, i_res.buy_order_id,
                                i_res.trade_price, i_res.trade_quantity,
                                i_res.total_volume, i_res.total_notional, i_res.last);
                if (expected_items.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item kind=%0d st=%0d id=%h px=%h q=%h vol=%h not=%h last=%b",
                             $time, got.kind, got.status, got.buy_id, got.price, got.qty,
                             got.vol, got.notional, got.last);
                end else begin
                    want = expected_items.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch expected kind=%0d st=%0d id=%h px=%h q=%h vol=%h not=%h last=%b",
                                 $time, want.kind, want.status, want.buy_id, want.price,
                                 want.qty, want.vol, want.notional, want.last);
                        $display("%0t:          actual   kind=%0d st=%0d id=%h px=%h q=%h vol=%h not=%h last=%b",
                                 $time, got.kind, got.status, got.buy_id, got.price, got.qty,
                                 got.vol, got.notional, got.last);
                    end
                end
            end
        end
    end
endmodule

[tb/sv/testbench.sv]
// Top of the limit order batch matcher bench: clock, reset, request stimulus and
// result back-pressure; the verdict comes from lobm_book_checker.
// Depends on lobm_pkg, lobm_req_if, lobm_res_if and the RTL top.
module testbench;
    import lobm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    int   cycles;
    int   items_sent;
    bit   calm;
    bit   hold_go;
    bit   hold_done;
    int   hold_cnt;

    lobm_req_if req_ch();
    lobm_res_if res_ch();

    limit_order_batch_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    lobm_book_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL limit_order_batch_matcher");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold while requests keep coming
    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= 400;
            res_ch.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    task automatic send_request(logic req_type, logic side, logic [15:0] id,
                                logic [31:0] price, logic [15:0] qty);
        int gap;
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= req_type;
        req_ch.side     <= side;
        req_ch.order_id <= id;
        req_ch.price    <= price;
        req_ch.quantity <= qty;
        do @(posedge i_clk); while (!req_ch.ready);
        items_sent++;
        gap = (!calm && $urandom_range(99) < 37) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic load_order(logic side, logic [15:0] id, logic [31:0] price,
                              logic [15:0] qty);
        send_request(REQ_LOAD, side, id, price, qty);
    endtask

    task automatic match_book();
        send_request(REQ_MATCH, 1'($urandom_range(1)), 16'($urandom), $urandom,
                     16'($urandom));
    endtask

    initial begin
        int n;
        logic [31:0] base;
        logic [31:0] px;
        logic [15:0] qty;
        cycles = 0;
        items_sent = 0;
        calm = 1'b0;
        hold_go = 1'b0;
        hold_done = 1'b0;
        hold_cnt = 0;
        res_ch.ready = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_LOAD;
        req_ch.side = SIDE_SELL;
        req_ch.order_id = '0;
        req_ch.price = '0;
        req_ch.quantity = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty book, invalid loads, field extremes
        match_book();
        load_order(SIDE_BUY, 16'h0001, 32'd0, 16'd5);
        load_order(SIDE_SELL, 16'h0002, 32'd7, 16'd0);
        load_order(SIDE_BUY, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        load_order(SIDE_SELL, 16'h0000, 32'd1, 16'd1);
        load_order(SIDE_SELL, 16'h5A5A, 32'hFFFF_FFFF, 16'h8000);
        load_order(SIDE_BUY, 16'hA5A5, 32'h0000_0001, 16'hFFFF);
        match_book();
        // full book with shared levels, then full and invalid on a full book
        for (int i = 0; i < MAX_ORDERS; i++)
            load_order(i[0], 16'(i * 16'h1111), 32'd100 + 32'(i % 3), 16'(1 + i * 3));
        load_order(SIDE_BUY, 16'h1234, 32'd101, 16'd9);
        load_order(SIDE_SELL, 16'h4321, 32'd0, 16'd0);
        match_book();

        hold_go = 1'b1;
        while (items_sent < 122) begin
            if (items_sent > 90 && items_sent < 120) calm = 1'b1;
            else calm = 1'b0;
            n = $urandom_range(0, MAX_ORDERS + 1);
            base = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : $urandom;
            if (base > 32'hFFFF_FF00) base = base - 32'h100;
            if (base == 0) base = 1;
            for (int i = 0; i < n; i++) begin
                px  = base + $urandom_range(0, 6);
                qty = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 60));
                if ($urandom_range(9) == 0) begin
                    if ($urandom_range(1)) px = '0;
                    else qty = '0;
                end
                load_order(1'($urandom_range(1)), 16'($urandom), px, qty);
            end
            match_book();
        end
        req_ch.valid <= 1'b0;
        calm = 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("PASS limit_order_batch_matcher");
        else
            $display("FAIL limit_order_batch_matcher");
        $finish;
    end
endmodule
